[sv/cau_pkg.sv]
// Package for the complex arithmetic unit: widths, operation and status codes,
// the structures that travel down the divider chain, and shared helper functions.
// No dependencies.
package cau_pkg;

	localparam int DW    = 32;          // width of one Q16.16 component
	localparam int FB    = 16;          // fraction bits
	localparam int PW    = 2 * DW;      // width of a full product
	localparam int SW    = 2 * DW + 1;  // width of a sum of two products
	localparam int SH    = DW - FB;     // alignment of the dividend against the divisor
	localparam int NCELL = DW;          // one divider cell per quotient bit

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MAG = 3'd4;
	localparam logic [2:0] OP_EQ  = 3'd5;
	localparam logic [2:0] OP_NE  = 3'd6;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	typedef struct packed {
		logic [DW-1:0] val;
		logic          sat;
	} sat_t;

	// One quotient lane: partial remainder, dividend bits still to shift in,
	// and quotient bits collected so far.
	typedef struct packed {
		logic [PW-1:0] rem;
		logic [DW-1:0] num;
		logic [DW-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic [2:0]    op;
		logic          neg_re;
		logic          neg_im;
		logic          big_re;
		logic          big_im;
		logic          den_zero;
		logic          cmp;
		logic          sat;
		logic [DW-1:0] res_re;
		logic [DW-1:0] res_im;
	} ctrl_t;

	typedef struct packed {
		ctrl_t         ctrl;
		logic [PW-1:0] den;
		lane_t         re;
		lane_t         im;
	} cell_t;

	// Turns a sign and a magnitude into a saturated two's complement component.
	function automatic sat_t sat_out(input logic neg, input logic [SW-1:0] mag);
		sat_t          r;
		logic [SW-1:0] lim;
		lim   = SW'(1) << (DW - 1);
		r.sat = 1'b0;
		if (neg) begin
			if (mag > lim) begin
				r.sat = 1'b1;
				r.val = lim[DW-1:0];
			end else begin
				r.val = DW'(~mag[DW-1:0] + DW'(1));
			end
		end else begin
			if (mag >= lim) begin
				r.sat = 1'b1;
				r.val = DW'(lim - SW'(1));
			end else begin
				r.val = mag[DW-1:0];
			end
		end
		return r;
	endfunction

	// One restoring division step: shift in the next dividend bit and subtract
	// the divisor when it fits.
	function automatic lane_t lane_step(input lane_t l, input logic [PW-1:0] den);
		lane_t       r;
		logic [PW:0] t;
		logic        q;
		t = {l.rem, l.num[DW-1]};
		q = (t >= {1'b0, den});
		if (q) begin
			r.rem = PW'(t - {1'b0, den});
		end else begin
			r.rem = t[PW-1:0];
		end
		r.num = {l.num[DW-2:0], 1'b0};
		r.quo = {l.quo[DW-2:0], q};
		return r;
	endfunction

endpackage

[sv/complex_arithmetic_unit_core.sv]
// Top level of the complex arithmetic unit: front end, divider cell chain and
// output register. Depends on cau_pkg, cau_front and cau_div_cell.
//
// Usage: drive operation and the four Q16.16 operand components and raise start
// for one cycle per item. busy is always low, so an item is taken at every edge
// at which start is high; a new item may follow in every cycle.
// Each item gives exactly one result: done is high for one cycle while
// result_real, result_imag, compare_true and status hold it. The receiver
// cannot hold results off, and none is needed: results leave in input order.
// Every operation takes the same path from the accepting edge to the result:
// five front-end stages (input register, multipliers, sums, magnitudes,
// saturation and divider setup), 32 divider cells that each settle one quotient
// bit of both lanes, and the output register. Throughput is one item per cycle.
// Division first checks whether the quotient reaches 2^32, which saturates, so
// the chain only needs one cell per result bit. Division by zero gives zero
// parts and the division-by-zero status.
// Reset (arst_n low) empties the pipeline at once; items in flight are dropped
// and done stays low until new items come through.
module complex_arithmetic_unit_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    operation,
	input  logic signed [cau_pkg::DW-1:0] a_real,
	input  logic signed [cau_pkg::DW-1:0] a_imag,
	input  logic signed [cau_pkg::DW-1:0] b_real,
	input  logic signed [cau_pkg::DW-1:0] b_imag,
	output logic                          done,
	output logic signed [cau_pkg::DW-1:0] result_real,
	output logic signed [cau_pkg::DW-1:0] result_imag,
	output logic                          compare_true,
	output logic [1:0]                    status
);
	import cau_pkg::*;

	// Every stage moves forward in every cycle, so the unit never refuses an item.
	assign busy = 1'b0;

	logic  chain_v [0:NCELL];
	cell_t chain_d [0:NCELL];

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.operation (operation),
		.a_real    (a_real),
		.a_imag    (a_imag),
		.b_real    (b_real),
		.b_imag    (b_imag),
		.out_valid (chain_v[0]),
		.out_data  (chain_d[0])
	);

	// The divider: each cell adds one quotient bit, most significant first.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		cau_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	// Final selection: quotients are saturated here, everything else was
	// finished in the front end and rode along with the item.
	cell_t         fin;
	sat_t          q_re, q_im;
	logic [DW-1:0] o_re, o_im;
	logic [1:0]    o_st;
	logic          o_cmp;

	always_comb begin
		fin = chain_d[NCELL];
		if (fin.ctrl.big_re) begin
			q_re.sat = 1'b1;
			q_re.val = fin.ctrl.neg_re ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			q_re = sat_out(fin.ctrl.neg_re, SW'(fin.re.quo));
		end
		if (fin.ctrl.big_im) begin
			q_im.sat = 1'b1;
			q_im.val = fin.ctrl.neg_im ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			q_im = sat_out(fin.ctrl.neg_im, SW'(fin.im.quo));
		end
		o_cmp = fin.ctrl.cmp;
		if (fin.ctrl.op == OP_DIV) begin
			if (fin.ctrl.den_zero) begin
				o_re = '0;
				o_im = '0;
				o_st = ST_DIVZ;
			end else begin
				o_re = q_re.val;
				o_im = q_im.val;
				o_st = (q_re.sat | q_im.sat) ? ST_SAT : ST_OK;
			end
		end else begin
			o_re = fin.ctrl.res_re;
			o_im = fin.ctrl.res_im;
			o_st = fin.ctrl.sat ? ST_SAT : ST_OK;
		end
	end

	logic          done_q;
	logic [DW-1:0] res_re_q, res_im_q;
	logic          cmp_q;
	logic [1:0]    status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_v[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		res_re_q <= o_re;
		res_im_q <= o_im;
		cmp_q    <= o_cmp;
		status_q <= o_st;
	end

	assign done         = done_q;
	assign result_real  = res_re_q;
	assign result_imag  = res_im_q;
	assign compare_true = cmp_q;
	assign status       = status_q;

`ifndef SYNTHESIS
	// A division by zero never carries a nonzero part.
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_DIVZ) |-> (result_real == '0) && (result_imag == '0))
		else $error("division by zero gave a nonzero result");

	// A true compare outcome comes with zero parts and an ok status.
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && compare_true |-> (status == ST_OK) && (result_real == '0) &&
			(result_imag == '0))
		else $error("compare result carries data or a status");

	// A saturated result has at least one part at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_SAT) |->
			(result_real == {1'b1, {(DW-1){1'b0}}}) || (result_real == {1'b0, {(DW-1){1'b1}}}) ||
			(result_imag == {1'b1, {(DW-1){1'b0}}}) || (result_imag == {1'b0, {(DW-1){1'b1}}}))
		else $error("saturation status without a saturated part");

	// The unused status code never appears.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 2'd3))
		else $error("unused status code");
`endif

endmodule

[sv/cau_div_cell.sv]
// One cell of the divider chain: a quotient bit for the real and imaginary lanes.
// Depends on cau_pkg.
module cau_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  cau_pkg::cell_t in_data,
	output logic          out_valid,
	output cau_pkg::cell_t out_data
);
	import cau_pkg::*;

	logic  valid_q;
	cell_t data_q;
	cell_t nxt;

	always_comb begin
		nxt      = in_data;
		nxt.re   = lane_step(in_data.re, in_data.den);
		nxt.im   = lane_step(in_data.im, in_data.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[sv/cau_front.sv]
// Front end of the unit: input register, products, sums, magnitudes and
// saturation, and the setup of the divider chain. Depends on cau_pkg.
module cau_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [2:0]                operation,
	input  logic signed [cau_pkg::DW-1:0] a_real,
	input  logic signed [cau_pkg::DW-1:0] a_imag,
	input  logic signed [cau_pkg::DW-1:0] b_real,
	input  logic signed [cau_pkg::DW-1:0] b_imag,
	output logic                      out_valid,
	output cau_pkg::cell_t            out_data
);
	import cau_pkg::*;

	// Stage 1: input register.
	logic                 valid_s1;
	logic [2:0]           op_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= operation;
		ar_s1 <= a_real;
		ai_s1 <= a_imag;
		br_s1 <= b_real;
		bi_s1 <= b_imag;
	end

	// Stage 2: six products, the short sums, and the compare.
	logic                 valid_s2;
	logic [2:0]           op_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [DW:0]   addre_s2, addim_s2;
	logic                 cmp_s2;
	logic signed [DW-1:0] m1b, m2b;
	logic signed [DW:0]   addre, addim;
	logic                 eq, cmp;

	always_comb begin
		m1b   = (op_s1 == OP_MAG) ? ar_s1 : br_s1;
		m2b   = (op_s1 == OP_MAG) ? ai_s1 : bi_s1;
		if (op_s1 == OP_SUB) begin
			addre = {ar_s1[DW-1], ar_s1} - {br_s1[DW-1], br_s1};
			addim = {ai_s1[DW-1], ai_s1} - {bi_s1[DW-1], bi_s1};
		end else begin
			addre = {ar_s1[DW-1], ar_s1} + {br_s1[DW-1], br_s1};
			addim = {ai_s1[DW-1], ai_s1} + {bi_s1[DW-1], bi_s1};
		end
		eq    = (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		cmp   = ((op_s1 == OP_EQ) && eq) || ((op_s1 == OP_NE) && !eq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		p1_s2    <= PW'(ar_s1) * PW'(m1b);
		p2_s2    <= PW'(ai_s1) * PW'(m2b);
		p3_s2    <= PW'(ar_s1) * PW'(bi_s1);
		p4_s2    <= PW'(ai_s1) * PW'(br_s1);
		p5_s2    <= PW'(br_s1) * PW'(br_s1);
		p6_s2    <= PW'(bi_s1) * PW'(bi_s1);
		addre_s2 <= addre;
		addim_s2 <= addim;
		cmp_s2   <= cmp;
	end

	// Stage 3: exact sums of products and the divisor.
	logic                 valid_s3;
	logic [2:0]           op_s3;
	logic signed [SW-1:0] re_s3, im_s3;
	logic [PW-1:0]        den_s3;
	logic                 cmp_s3;
	logic signed [SW-1:0] e1, e2, e3, e4, re, im;

	always_comb begin
		e1 = {p1_s2[PW-1], p1_s2};
		e2 = {p2_s2[PW-1], p2_s2};
		e3 = {p3_s2[PW-1], p3_s2};
		e4 = {p4_s2[PW-1], p4_s2};
		re = '0;
		im = '0;
		case (op_s2)
			OP_ADD, OP_SUB: begin
				re = SW'(addre_s2);
				im = SW'(addim_s2);
			end
			OP_MUL: begin
				re = e1 - e2;
				im = e3 + e4;
			end
			OP_DIV: begin
				re = e1 + e2;
				im = e4 - e3;
			end
			OP_MAG: begin
				re = e1 + e2;
			end
			default: begin
				re = '0;
				im = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		re_s3  <= re;
		im_s3  <= im;
		den_s3 <= $unsigned(p5_s2) + $unsigned(p6_s2);
		cmp_s3 <= cmp_s2;
	end

	// Stage 4: sign and magnitude, with the fraction shift for multiply and magnitude results.
	logic                 valid_s4;
	logic [2:0]           op_s4;
	logic                 neg_re_s4, neg_im_s4;
	logic [SW-1:0]        mag_re_s4, mag_im_s4;
	logic [PW-1:0]        den_s4;
	logic                 cmp_s4;
	logic [SW-1:0]        mre, mim;
	logic                 shift;

	always_comb begin
		mre   = re_s3[SW-1] ? SW'(-re_s3) : SW'(re_s3);
		mim   = im_s3[SW-1] ? SW'(-im_s3) : SW'(im_s3);
		shift = (op_s3 == OP_MUL) || (op_s3 == OP_MAG);
		if (shift) begin
			mre = mre >> FB;
			mim = mim >> FB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s4     <= op_s3;
		neg_re_s4 <= re_s3[SW-1];
		neg_im_s4 <= im_s3[SW-1];
		mag_re_s4 <= mre;
		mag_im_s4 <= mim;
		den_s4    <= den_s3;
		cmp_s4    <= cmp_s3;
	end

	// Stage 5: saturation of direct results, quotient range check, lane setup.
	logic  valid_s5;
	cell_t cell_s5;
	cell_t cnxt;
	sat_t  s_re, s_im;

	always_comb begin
		s_re               = sat_out(neg_re_s4, mag_re_s4);
		s_im               = sat_out(neg_im_s4, mag_im_s4);
		cnxt.ctrl.op       = op_s4;
		cnxt.ctrl.neg_re   = neg_re_s4;
		cnxt.ctrl.neg_im   = neg_im_s4;
		cnxt.ctrl.big_re   = {{(PW + SH - SW){1'b0}}, mag_re_s4} >= {den_s4, {SH{1'b0}}};
		cnxt.ctrl.big_im   = {{(PW + SH - SW){1'b0}}, mag_im_s4} >= {den_s4, {SH{1'b0}}};
		cnxt.ctrl.den_zero = (den_s4 == '0);
		cnxt.ctrl.cmp      = cmp_s4;
		cnxt.ctrl.sat      = s_re.sat | s_im.sat;
		cnxt.ctrl.res_re   = s_re.val;
		cnxt.ctrl.res_im   = s_im.val;
		cnxt.den           = den_s4;
		cnxt.re.rem        = PW'(mag_re_s4 >> SH);
		cnxt.re.num        = {mag_re_s4[SH-1:0], {FB{1'b0}}};
		cnxt.re.quo        = '0;
		cnxt.im.rem        = PW'(mag_im_s4 >> SH);
		cnxt.im.num        = {mag_im_s4[SH-1:0], {FB{1'b0}}};
		cnxt.im.quo        = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		cell_s5 <= cnxt;
	end

	assign out_valid = valid_s5;
	assign out_data  = cell_s5;

endmodule

[tb/complex_arithmetic_unit_core_tb.sv]
// Self-checking testbench for complex_arithmetic_unit_core: directed table, then random items,
// every result checked against a wide-integer predictor of the Q16.16 arithmetic.
// Depends on cau_pkg and the complex_arithmetic_unit_core RTL.
module complex_arithmetic_unit_core_tb;
	import cau_pkg::*;

	typedef struct packed {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic                 cmp;
		logic [1:0]           st;
	} cplx_result_t;

	// One row of the directed table. Where known is set, the expected result is
	// typed in and checked against the predictor as well.
	typedef struct {
		logic [2:0]           op;
		logic signed [DW-1:0] ar, ai, br, bi;
		logic                 known;
		cplx_result_t         exp;
	} vector_t;

	localparam int N_RANDOM    = 900;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic signed [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] ONE  = DW'(1) << FB;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [2:0]           operation = OP_ADD;
	logic signed [DW-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic                 done;
	logic signed [DW-1:0] result_real, result_imag;
	logic                 compare_true;
	logic [1:0]           status;

	cplx_result_t pending_results[$];
	logic         busy_s = 1'b0;
	bit           failed = 1'b0;
	int           cycles = 0;

	complex_arithmetic_unit_core i_dut (
		.clk, .arst_n, .start, .busy, .operation,
		.a_real, .a_imag, .b_real, .b_imag,
		.done, .result_real, .result_imag, .compare_true, .status
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamps an exact value to the signed component range and flags saturation.
	function automatic logic signed [DW-1:0] clamp(input logic signed [127:0] v, inout logic sat);
		if (v > 128'(QMAX)) begin
			sat = 1'b1;
			return QMAX;
		end
		if (v < 128'(QMIN)) begin
			sat = 1'b1;
			return QMIN;
		end
		return v[DW-1:0];
	endfunction

	// Drops the fraction bits of an exact product sum, rounding toward zero.
	function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
		if (v < 0) return -((-v) >>> FB);
		return v >>> FB;
	endfunction

	function automatic cplx_result_t compute_cplx(input logic [2:0] op,
			input logic signed [DW-1:0] ar_i, ai_i, br_i, bi_i);
		cplx_result_t r;
		logic signed [127:0] ar, ai, br, bi, x, y, den;
		logic sat;
		ar = 128'(ar_i); ai = 128'(ai_i); br = 128'(br_i); bi = 128'(bi_i);
		x = '0; y = '0; sat = 1'b0;
		r.cmp = 1'b0;
		r.st  = ST_OK;
		case (op)
			OP_ADD: begin
				x = ar + br; y = ai + bi;
			end
			OP_SUB: begin
				x = ar - br; y = ai - bi;
			end
			OP_MUL: begin
				x = drop_frac(ar * br - ai * bi);
				y = drop_frac(ar * bi + ai * br);
			end
			OP_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.st = ST_DIVZ;
				end else begin
					// Signed division in SystemVerilog already truncates toward zero.
					x = ((ar * br + ai * bi) <<< FB) / den;
					y = ((ai * br - ar * bi) <<< FB) / den;
				end
			end
			OP_MAG: begin
				x = drop_frac(ar * ar + ai * ai);
			end
			OP_EQ, OP_NE: begin
				r.cmp = ((ar_i == br_i) && (ai_i == bi_i)) ^ (op == OP_NE);
			end
			default: begin
			end
		endcase
		r.re = clamp(x, sat);
		r.im = clamp(y, sat);
		if (r.st == ST_OK && sat) r.st = ST_SAT;
		return r;
	endfunction

	// busy only moves at rising edges, so its value at the falling edge is the one
	// the next rising edge sees.
	always @(negedge clk) busy_s <= busy;

	// Record an expectation for each item the block takes. Inputs still hold their
	// pre-edge values here because the driver updates them with nonblocking writes.
	always @(posedge clk) begin
		if (arst_n && start && !busy_s)
			pending_results.push_back(compute_cplx(operation, a_real, a_imag, b_real, b_imag));
	end

	// Results are stable for the whole cycle that done marks, so the falling edge
	// is a race-free place to compare them.
	always @(negedge clk) begin
		cplx_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				failed = 1'b1;
			end else begin
				e = pending_results.pop_front();
				if (result_real !== e.re) begin
					$error("result_real: expected %h, got %h", e.re, result_real);
					failed = 1'b1;
				end
				if (result_imag !== e.im) begin
					$error("result_imag: expected %h, got %h", e.im, result_imag);
					failed = 1'b1;
				end
				if (compare_true !== e.cmp) begin
					$error("compare_true: expected %b, got %b", e.cmp, compare_true);
					failed = 1'b1;
				end
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Presents one item, holds it until taken, then often drops start and idles for a random gap.
	task automatic send_item(input logic [2:0] op,
			input logic signed [DW-1:0] ar, ai, br, bi);
		int gap;
		operation <= op;
		a_real    <= ar;
		a_imag    <= ai;
		b_real    <= br;
		b_imag    <= bi;
		start     <= 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		// A little over a third of the items follow back to back.
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Operand draw: moderate values are the largest share so products and quotients stay in range,
	// with full-range and boundary values mixed in to reach saturation.
	function automatic logic signed [DW-1:0] draw_operand();
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3:       return $urandom_range(0, 1) ? QMAX : QMIN;
			4:       return DW'($urandom_range(0, 4)) - DW'(2);
			5:       return 0;
			default: return DW'(signed'(DW'($urandom_range(0, 1 << 22)) - DW'(1 << 21)));
		endcase
	endfunction

	initial begin
		vector_t              dir_table[$];
		vector_t              v;
		cplx_result_t         z;
		logic [2:0]           op;
		logic signed [DW-1:0] ar, ai, br, bi;
		int                   wait_cycles;

		z = '{re: '0, im: '0, cmp: 1'b0, st: ST_OK};
		// Extremes, every operation, division by zero, compares both ways, unused code.
		dir_table = '{
			'{OP_ADD, QMAX, QMAX, QMAX, QMAX, 1'b1, '{QMAX, QMAX, 1'b0, ST_SAT}},
			'{OP_ADD, QMIN, 0, QMIN, 0, 1'b1, '{QMIN, 0, 1'b0, ST_SAT}},
			'{OP_SUB, QMIN, QMAX, 1, -1, 1'b1, '{QMIN, QMAX, 1'b0, ST_SAT}},
			'{OP_SUB, 0, 0, QMIN, QMIN, 1'b1, '{QMAX, QMAX, 1'b0, ST_SAT}},
			'{OP_ADD, ONE, -ONE, ONE, ONE, 1'b1, '{2 * ONE, 0, 1'b0, ST_OK}},
			'{OP_MUL, ONE, 0, -ONE, 0, 1'b1, '{-ONE, 0, 1'b0, ST_OK}},
			'{OP_MUL, QMIN, QMIN, QMIN, QMIN, 1'b0, z},
			'{OP_MUL, -1, 1, 1, 1, 1'b0, z},
			'{OP_MUL, 3 * ONE, 2 * ONE, -ONE / 2, 7, 1'b0, z},
			'{OP_DIV, ONE, ONE, 0, 0, 1'b1, '{0, 0, 1'b0, ST_DIVZ}},
			'{OP_DIV, QMAX, QMIN, 0, 0, 1'b1, '{0, 0, 1'b0, ST_DIVZ}},
			'{OP_DIV, ONE, 0, 1, 0, 1'b1, '{QMAX, 0, 1'b0, ST_SAT}},
			'{OP_DIV, QMIN, QMAX, QMIN, QMIN, 1'b0, z},
			'{OP_DIV, -7, 5, 3 * ONE, -ONE, 1'b0, z},
			'{OP_DIV, ONE, 0, 2 * ONE, 0, 1'b1, '{ONE / 2, 0, 1'b0, ST_OK}},
			'{OP_MAG, QMIN, QMIN, 0, 0, 1'b1, '{QMAX, 0, 1'b0, ST_SAT}},
			'{OP_MAG, 3 * ONE, -4 * ONE, 0, 0, 1'b1, '{25 * ONE, 0, 1'b0, ST_OK}},
			'{OP_MAG, -1, 1, 0, 0, 1'b1, z},
			'{OP_EQ, QMIN, QMAX, QMIN, QMAX, 1'b1, '{0, 0, 1'b1, ST_OK}},
			'{OP_EQ, QMIN, QMAX, QMIN, QMIN, 1'b1, z},
			'{OP_NE, 5, 6, 5, 6, 1'b1, z},
			'{OP_NE, 5, 6, 5, 7, 1'b1, '{0, 0, 1'b1, ST_OK}},
			'{OP_UNUSED, QMAX, QMIN, -1, 1, 1'b1, z}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			v = dir_table[i];
			// Typed-in rows also cross-check the predictor itself.
			if (v.known && compute_cplx(v.op, v.ar, v.ai, v.br, v.bi) !== v.exp) begin
				$error("directed row %0d: predictor disagrees with table", i);
				failed = 1'b1;
			end
			send_item(v.op, v.ar, v.ai, v.br, v.bi);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			op = 3'($urandom_range(0, 7));
			ar = draw_operand();
			ai = draw_operand();
			br = draw_operand();
			bi = draw_operand();
			// Compares need equal operands often enough to see both outcomes.
			if ((op == OP_EQ || op == OP_NE) && $urandom_range(0, 1)) begin
				br = ar;
				if ($urandom_range(0, 2) != 0) bi = ai;
			end
			// Occasional zero divisor.
			if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
				br = 0;
				bi = 0;
			end
			send_item(op, ar, ai, br, bi);
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (50) @(posedge clk);

		if (!failed && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			if (pending_results.size() != 0)
				$error("%0d results never arrived", pending_results.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
